// ===== sv/icmpv4_pkg.sv =====
// Shared types and constants of the ICMPv4 header decoder.
package icmpv4_pkg;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_SHORT        = 3'd1,
    EV_BAD_CODE     = 3'd2,
    EV_BAD_TYPE     = 3'd3,
    EV_INNER_SHORT  = 3'd4,
    EV_INNER_VER    = 3'd5
  } icmpv4_event_t;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
  localparam logic [7:0] TYPE_SOURCE_QUENCH = 8'd4;
  localparam logic [7:0] TYPE_REDIRECT      = 8'd5;
  localparam logic [7:0] TYPE_ECHO          = 8'd8;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] TYPE_PARAM_PROBLEM = 8'd12;
  localparam logic [7:0] TYPE_TSTAMP        = 8'd13;
  localparam logic [7:0] TYPE_TSTAMP_REPLY  = 8'd14;
  localparam logic [7:0] TYPE_INFO          = 8'd15;
  localparam logic [7:0] TYPE_INFO_REPLY    = 8'd16;
  localparam logic [7:0] TYPE_ADDR          = 8'd17;
  localparam logic [7:0] TYPE_ADDR_REPLY    = 8'd18;

  localparam logic [7:0] LIMIT_DEST_UNREACH  = 8'd15;
  localparam logic [7:0] LIMIT_SOURCE_QUENCH = 8'd0;
  localparam logic [7:0] LIMIT_REDIRECT      = 8'd3;
  localparam logic [7:0] LIMIT_TIME_EXCEEDED = 8'd1;
  localparam logic [7:0] LIMIT_PARAM_PROBLEM = 8'd0;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [3:0] IP_VERSION = 4'd4;

  localparam logic [15:0] OFS_TYPE    = 16'd0;
  localparam logic [15:0] OFS_CODE    = 16'd1;
  localparam logic [15:0] OFS_IDENT0  = 16'd4;
  localparam logic [15:0] OFS_IDENT1  = 16'd5;
  localparam logic [15:0] OFS_SEQ0    = 16'd6;
  localparam logic [15:0] OFS_SEQ1    = 16'd7;
  localparam logic [15:0] OFS_VER_IHL = 16'd8;
  localparam logic [15:0] OFS_PROTO   = 16'd17;
  localparam logic [15:0] OFS_SRC0    = 16'd20;
  localparam logic [15:0] OFS_SRC1    = 16'd21;
  localparam logic [15:0] OFS_SRC2    = 16'd22;
  localparam logic [15:0] OFS_SRC3    = 16'd23;
  localparam logic [15:0] OFS_DST0    = 16'd24;
  localparam logic [15:0] OFS_DST1    = 16'd25;
  localparam logic [15:0] OFS_DST2    = 16'd26;
  localparam logic [15:0] OFS_DST3    = 16'd27;
  localparam logic [15:0] OFS_SPORT0  = 16'd28;
  localparam logic [15:0] OFS_SPORT1  = 16'd29;
  localparam logic [15:0] OFS_DPORT0  = 16'd30;
  localparam logic [15:0] OFS_DPORT1  = 16'd31;

  // message lengths: ICMP header, plus quoted IP header, plus UDP or TCP header
  localparam logic [15:0] LEN_HDR       = 16'd8;
  localparam logic [15:0] LEN_INNER_MIN = 16'd28;
  localparam logic [15:0] LEN_UDP_MIN   = 16'd36;
  localparam logic [15:0] LEN_TCP_MIN   = 16'd48;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } icmpv4_fields_t;

  typedef struct packed {
    logic [7:0]    msg_type;
    logic [7:0]    msg_code;
    logic [15:0]   ident;
    logic [15:0]   sequence_res;
    icmpv4_event_t event_res;
    logic          inner_valid;
    logic [31:0]   inner_src;
    logic [31:0]   inner_dst;
    logic [5:0]    inner_hdr_len;
    logic [7:0]    inner_proto;
    logic [15:0]   inner_src_port;
    logic [15:0]   inner_dst_port;
  } icmpv4_result_t;

endpackage

// ===== sv/icmpv4_msg_if.sv =====
// Byte channel carrying the ICMP message into the decoder.
interface icmpv4_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source(output valid, byte_in, last_byte, input ready);
  modport sink(input valid, byte_in, last_byte, output ready);
endinterface

// ===== sv/icmpv4_res_if.sv =====
// Result channel carrying one decode result per message.
interface icmpv4_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_type;
  logic [7:0]  msg_code;
  logic [15:0] ident;
  logic [15:0] sequence_res;
  logic [2:0]  event_res;
  logic        inner_valid;
  logic [31:0] inner_src;
  logic [31:0] inner_dst;
  logic [5:0]  inner_hdr_len;
  logic [7:0]  inner_proto;
  logic [15:0] inner_src_port;
  logic [15:0] inner_dst_port;

  modport source(output valid, msg_type, msg_code, ident, sequence_res, event_res,
                 inner_valid, inner_src, inner_dst, inner_hdr_len, inner_proto,
                 inner_src_port, inner_dst_port,
                 input ready);
  modport sink(input valid, msg_type, msg_code, ident, sequence_res, event_res,
               inner_valid, inner_src, inner_dst, inner_hdr_len, inner_proto,
               inner_src_port, inner_dst_port,
               output ready);
endinterface

// ===== sv/icmpv4_decode.sv =====
// Classification of a captured ICMP header into one decode result.
module icmpv4_decode (
  input  icmpv4_pkg::icmpv4_fields_t fields,
  input  logic [15:0]                len,
  output icmpv4_pkg::icmpv4_result_t result
);
  import icmpv4_pkg::*;

  logic       query;
  logic       err;
  logic [7:0] limit;
  logic       ports_ok;

  always_comb begin
    query = 1'b0;
    err   = 1'b0;
    limit = '0;
    case (fields.msg_type)
      TYPE_ECHO_REPLY, TYPE_ECHO, TYPE_TSTAMP, TYPE_TSTAMP_REPLY,
      TYPE_INFO, TYPE_INFO_REPLY, TYPE_ADDR, TYPE_ADDR_REPLY: begin
        query = 1'b1;
      end
      TYPE_DEST_UNREACH: begin
        err = 1'b1;
        limit = LIMIT_DEST_UNREACH;
      end
      TYPE_SOURCE_QUENCH: begin
        err = 1'b1;
        limit = LIMIT_SOURCE_QUENCH;
      end
      TYPE_REDIRECT: begin
        err = 1'b1;
        limit = LIMIT_REDIRECT;
      end
      TYPE_TIME_EXCEEDED: begin
        err = 1'b1;
        limit = LIMIT_TIME_EXCEEDED;
      end
      TYPE_PARAM_PROBLEM: begin
        err = 1'b1;
        limit = LIMIT_PARAM_PROBLEM;
      end
      default: begin
        query = 1'b0;
      end
    endcase
  end

  assign ports_ok = (fields.proto == PROTO_TCP && len >= LEN_TCP_MIN) ||
                    (fields.proto == PROTO_UDP && len >= LEN_UDP_MIN);

  always_comb begin
    result = '0;
    if (len < LEN_HDR) begin
      result.event_res = EV_SHORT;
    end else begin
      result.msg_type = fields.msg_type;
      result.msg_code = fields.msg_code;
      if (query) begin
        result.ident        = fields.ident;
        result.sequence_res = fields.seq;
        if (fields.msg_code != '0) begin
          result.event_res = EV_BAD_CODE;
        end
      end else if (err) begin
        if (fields.msg_code > limit) begin
          result.event_res = EV_BAD_CODE;
        end else if (len < LEN_INNER_MIN) begin
          result.event_res = EV_INNER_SHORT;
        end else if (fields.version != IP_VERSION) begin
          result.event_res = EV_INNER_VER;
        end else begin
          result.inner_valid   = 1'b1;
          result.inner_src     = fields.src_addr;
          result.inner_dst     = fields.dst_addr;
          result.inner_hdr_len = {fields.ihl, 2'b00};
          result.inner_proto   = fields.proto;
          if (ports_ok) begin
            result.inner_src_port = fields.src_port;
            result.inner_dst_port = fields.dst_port;
          end
        end
      end else begin
        result.event_res = EV_BAD_TYPE;
      end
    end
  end

endmodule

// ===== sv/icmpv4_header_decoder.sv =====
// Top level of the ICMPv4 header decoder.
//
// The msg channel carries an ICMP message one byte per item, header first;
// last_byte marks the final byte. Each byte is captured by its position in
// the message. On the final byte the decoder produces one item on the res
// channel with type, code, identifier and sequence, an event code, and the
// addresses, length, protocol and ports of a quoted IPv4 header.
//
// Throughput is one byte per cycle while no result waits on a stalled receiver.
// The result of a message is registered and appears on res in the cycle after
// its last byte is accepted. Capture and classification are combinational,
// from the capture registers and the incoming byte into the result register.
//
// Reset (rst, synchronous) clears the byte count and all captured fields and
// empties the result register. While a result waits on a stalled receiver,
// msg.ready stays low only if that result is not taken in the same cycle;
// otherwise bytes keep flowing, since the result register frees up as the
// next result is loaded.
module icmpv4_header_decoder (
  input  logic clk,
  input  logic rst,
  icmpv4_msg_if.sink   msg,
  icmpv4_res_if.source res
);
  import icmpv4_pkg::*;

  logic [15:0]    byte_count;
  logic [15:0]    byte_count_next;
  icmpv4_fields_t fields;
  icmpv4_fields_t fields_next;
  icmpv4_result_t result_next;
  icmpv4_result_t result;
  logic           res_valid;
  logic           accept;

  assign msg.ready = !res_valid || res.ready;
  assign accept    = msg.valid && msg.ready;

  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;

  always_comb begin
    fields_next = fields;
    case (byte_count)
      OFS_TYPE: fields_next.msg_type = msg.byte_in;
      OFS_CODE: fields_next.msg_code = msg.byte_in;
      OFS_IDENT0, OFS_IDENT1: fields_next.ident = {fields.ident[7:0], msg.byte_in};
      OFS_SEQ0, OFS_SEQ1: fields_next.seq = {fields.seq[7:0], msg.byte_in};
      OFS_VER_IHL: begin
        fields_next.version = msg.byte_in[7:4];
        fields_next.ihl     = msg.byte_in[3:0];
      end
      OFS_PROTO: fields_next.proto = msg.byte_in;
      OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3:
        fields_next.src_addr = {fields.src_addr[23:0], msg.byte_in};
      OFS_DST0, OFS_DST1, OFS_DST2, OFS_DST3:
        fields_next.dst_addr = {fields.dst_addr[23:0], msg.byte_in};
      OFS_SPORT0, OFS_SPORT1: fields_next.src_port = {fields.src_port[7:0], msg.byte_in};
      OFS_DPORT0, OFS_DPORT1: fields_next.dst_port = {fields.dst_port[7:0], msg.byte_in};
      default: fields_next = fields;
    endcase
  end

  icmpv4_decode u_decode (
    .fields (fields_next),
    .len    (byte_count_next),
    .result (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      fields     <= '0;
    end else if (accept) begin
      if (msg.last_byte) begin
        byte_count <= '0;
        fields     <= '0;
      end else begin
        byte_count <= byte_count_next;
        fields     <= fields_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && msg.last_byte) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg.last_byte) begin
      result <= result_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.msg_type       = result.msg_type;
  assign res.msg_code       = result.msg_code;
  assign res.ident          = result.ident;
  assign res.sequence_res   = result.sequence_res;
  assign res.event_res      = result.event_res;
  assign res.inner_valid    = result.inner_valid;
  assign res.inner_src      = result.inner_src;
  assign res.inner_dst      = result.inner_dst;
  assign res.inner_hdr_len  = result.inner_hdr_len;
  assign res.inner_proto    = result.inner_proto;
  assign res.inner_src_port = result.inner_src_port;
  assign res.inner_dst_port = result.inner_dst_port;

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    accept && msg.last_byte |=> byte_count == '0)
    else $error("byte count not cleared after last byte");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && msg.last_byte |=> res_valid)
    else $error("no result after last byte");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !msg.ready |-> res_valid && !res.ready)
    else $error("input stalled without a pending result");

  a_inner_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.inner_valid |->
      result.inner_src == '0 && result.inner_dst == '0 && result.inner_hdr_len == '0 &&
      result.inner_proto == '0 && result.inner_src_port == '0 &&
      result.inner_dst_port == '0)
    else $error("inner fields set without a decoded quoted header");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.event_res == EV_SHORT |->
      result.msg_type == '0 && result.msg_code == '0 && result.ident == '0)
    else $error("short message carries header fields");

endmodule

// ===== tb/icmpv4_header_decoder_checker.sv =====
// Checker for the ICMPv4 header decoder: tracks message bytes, predicts and compares results.
module icmpv4_header_decoder_checker (
  input  logic  clk,
  input  logic  rst,
  icmpv4_msg_if msg,
  icmpv4_res_if res,
  output int    outstanding,
  output int    failures
);
  import icmpv4_pkg::*;

  icmpv4_fields_t captured;
  logic [15:0]    byte_pos;
  icmpv4_result_t due_decodes[$];

  function automatic string format_decode(icmpv4_result_t r);
    return $sformatf({"type=%0d code=%0d id=%h seq=%h ev=%0d iv=%b src=%h dst=%h",
                      " hlen=%0d proto=%0d sport=%h dport=%h"},
                     r.msg_type, r.msg_code, r.ident, r.sequence_res, r.event_res,
                     r.inner_valid, r.inner_src, r.inner_dst, r.inner_hdr_len,
                     r.inner_proto, r.inner_src_port, r.inner_dst_port);
  endfunction

  task automatic log_failure(string what);
    failures++;
    if (failures <= 10) $display("%s", what);
  endtask

  task automatic take_byte(logic [7:0] b, logic lst);
    icmpv4_result_t r;
    logic [15:0]    len;
    logic           query;
    logic           error_type;
    logic [7:0]     limit;
    case (byte_pos)
      OFS_TYPE: captured.msg_type = b;
      OFS_CODE: captured.msg_code = b;
      OFS_IDENT0, OFS_IDENT1: captured.ident = {captured.ident[7:0], b};
      OFS_SEQ0, OFS_SEQ1: captured.seq = {captured.seq[7:0], b};
      OFS_VER_IHL: {captured.version, captured.ihl} = b;
      OFS_PROTO: captured.proto = b;
      OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3: captured.src_addr = {captured.src_addr[23:0], b};
      OFS_DST0, OFS_DST1, OFS_DST2, OFS_DST3: captured.dst_addr = {captured.dst_addr[23:0], b};
      OFS_SPORT0, OFS_SPORT1: captured.src_port = {captured.src_port[7:0], b};
      OFS_DPORT0, OFS_DPORT1: captured.dst_port = {captured.dst_port[7:0], b};
      default: ;
    endcase
    len = (byte_pos == COUNT_MAX) ? COUNT_MAX : byte_pos + 16'd1;
    byte_pos = len;
    if (lst) begin
      r = '0;
      query = 1'b0;
      error_type = 1'b0;
      limit = '0;
      if (len < LEN_HDR) begin
        r.event_res = EV_SHORT;
      end else begin
        r.msg_type = captured.msg_type;
        r.msg_code = captured.msg_code;
        case (captured.msg_type)
          TYPE_ECHO_REPLY, TYPE_ECHO, TYPE_TSTAMP, TYPE_TSTAMP_REPLY, TYPE_INFO,
          TYPE_INFO_REPLY, TYPE_ADDR, TYPE_ADDR_REPLY: query = 1'b1;
          TYPE_DEST_UNREACH: begin
            error_type = 1'b1;
            limit = LIMIT_DEST_UNREACH;
          end
          TYPE_SOURCE_QUENCH: begin
            error_type = 1'b1;
            limit = LIMIT_SOURCE_QUENCH;
          end
          TYPE_REDIRECT: begin
            error_type = 1'b1;
            limit = LIMIT_REDIRECT;
          end
          TYPE_TIME_EXCEEDED: begin
            error_type = 1'b1;
            limit = LIMIT_TIME_EXCEEDED;
          end
          TYPE_PARAM_PROBLEM: begin
            error_type = 1'b1;
            limit = LIMIT_PARAM_PROBLEM;
          end
          default: r.event_res = EV_BAD_TYPE;
        endcase
        if (query) begin
          r.ident = captured.ident;
          r.sequence_res = captured.seq;
          if (captured.msg_code != 8'd0) r.event_res = EV_BAD_CODE;
        end else if (error_type) begin
          if (captured.msg_code > limit) begin
            r.event_res = EV_BAD_CODE;
          end else if (len < LEN_INNER_MIN) begin
            r.event_res = EV_INNER_SHORT;
          end else if (captured.version != IP_VERSION) begin
            r.event_res = EV_INNER_VER;
          end else begin
            r.inner_valid = 1'b1;
            r.inner_src = captured.src_addr;
            r.inner_dst = captured.dst_addr;
            r.inner_hdr_len = {captured.ihl, 2'b00};
            r.inner_proto = captured.proto;
            if ((captured.proto == PROTO_TCP && len >= LEN_TCP_MIN) ||
                (captured.proto == PROTO_UDP && len >= LEN_UDP_MIN)) begin
              r.inner_src_port = captured.src_port;
              r.inner_dst_port = captured.dst_port;
            end
          end
        end
      end
      due_decodes.push_back(r);
      captured = '0;
      byte_pos = '0;
    end
  endtask

  task automatic check_result();
    icmpv4_result_t got;
    icmpv4_result_t want;
    string          diffs;
    got.msg_type = res.msg_type;
    got.msg_code = res.msg_code;
    got.ident = res.ident;
    got.sequence_res = res.sequence_res;
    got.event_res = icmpv4_event_t'(res.event_res);
    got.inner_valid = res.inner_valid;
    got.inner_src = res.inner_src;
    got.inner_dst = res.inner_dst;
    got.inner_hdr_len = res.inner_hdr_len;
    got.inner_proto = res.inner_proto;
    got.inner_src_port = res.inner_src_port;
    got.inner_dst_port = res.inner_dst_port;
    if (due_decodes.size() == 0) begin
      log_failure($sformatf("unexpected result: %s", format_decode(got)));
    end else begin
      want = due_decodes.pop_front();
      diffs = "";
      if (got.msg_type !== want.msg_type) diffs = {diffs, " msg_type"};
      if (got.msg_code !== want.msg_code) diffs = {diffs, " msg_code"};
      if (got.ident !== want.ident) diffs = {diffs, " ident"};
      if (got.sequence_res !== want.sequence_res) diffs = {diffs, " sequence_res"};
      if (got.event_res !== want.event_res) diffs = {diffs, " event_res"};
      if (got.inner_valid !== want.inner_valid) diffs = {diffs, " inner_valid"};
      if (got.inner_src !== want.inner_src) diffs = {diffs, " inner_src"};
      if (got.inner_dst !== want.inner_dst) diffs = {diffs, " inner_dst"};
      if (got.inner_hdr_len !== want.inner_hdr_len) diffs = {diffs, " inner_hdr_len"};
      if (got.inner_proto !== want.inner_proto) diffs = {diffs, " inner_proto"};
      if (got.inner_src_port !== want.inner_src_port) diffs = {diffs, " inner_src_port"};
      if (got.inner_dst_port !== want.inner_dst_port) diffs = {diffs, " inner_dst_port"};
      if (diffs != "")
        log_failure($sformatf("result mismatch in%s\n  expected %s\n  actual   %s",
                              diffs, format_decode(want), format_decode(got)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      captured = '0;
      byte_pos = '0;
      due_decodes.delete();
    end else begin
      if (res.valid && res.ready) check_result();
      if (msg.valid && msg.ready) take_byte(msg.byte_in, msg.last_byte);
    end
    outstanding <= due_decodes.size();
  end

endmodule

// ===== tb/icmpv4_header_decoder_test.sv =====
// Testbench top for the ICMPv4 header decoder: message stimulus, receiver stalls and verdict.
module icmpv4_header_decoder_test;
  import icmpv4_pkg::*;

  typedef logic [7:0] msg_bytes_t[$];

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 560;
  localparam int RANDOM_MSGS  = 33;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   outstanding;
  int   failures;
  bit   idle_on;
  int   stall_left = 0;
  int   bytes_sent;
  int   msgs_sent;

  logic [7:0] query_types [8] = '{TYPE_ECHO_REPLY, TYPE_ECHO, TYPE_TSTAMP, TYPE_TSTAMP_REPLY,
                                  TYPE_INFO, TYPE_INFO_REPLY, TYPE_ADDR, TYPE_ADDR_REPLY};
  logic [7:0] err_types [5] = '{TYPE_DEST_UNREACH, TYPE_SOURCE_QUENCH, TYPE_REDIRECT,
                                TYPE_TIME_EXCEEDED, TYPE_PARAM_PROBLEM};
  logic [7:0] err_limits [5] = '{LIMIT_DEST_UNREACH, LIMIT_SOURCE_QUENCH, LIMIT_REDIRECT,
                                 LIMIT_TIME_EXCEEDED, LIMIT_PARAM_PROBLEM};

  icmpv4_msg_if msg ();
  icmpv4_res_if res ();

  icmpv4_header_decoder u_dut (
    .clk (clk),
    .rst (rst),
    .msg (msg),
    .res (res)
  );

  icmpv4_header_decoder_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg),
    .res         (res),
    .outstanding (outstanding),
    .failures    (failures)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      msg.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg.valid <= 1'b1;
    msg.byte_in <= b;
    msg.last_byte <= lst;
    do @(posedge clk); while (msg.ready !== 1'b1);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(msg_bytes_t head, int total);
    for (int i = 0; i < total; i++)
      send_byte(i < head.size() ? head[i] : 8'($urandom), i == total - 1);
    msgs_sent++;
  endtask

  function automatic msg_bytes_t make_head(logic [7:0] t, logic [7:0] c, logic [3:0] v,
                                           logic [3:0] ihl, logic [7:0] p);
    msg_bytes_t h;
    for (int i = 0; i < 32; i++) h.push_back(8'($urandom));
    h[OFS_TYPE] = t;
    h[OFS_CODE] = c;
    h[OFS_VER_IHL] = {v, ihl};
    h[OFS_PROTO] = p;
    return h;
  endfunction

  task automatic send_random_message();
    logic [7:0] t;
    logic [7:0] c;
    logic [7:0] p;
    logic [3:0] v;
    int         len;
    int         pick;
    int         k;
    pick = $urandom_range(0, 9);
    v = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IP_VERSION;
    case ($urandom_range(0, 4))
      0, 1: p = PROTO_TCP;
      2, 3: p = PROTO_UDP;
      default: p = 8'($urandom);
    endcase
    if (pick <= 3) begin
      t = query_types[$urandom_range(0, 7)];
      c = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0;
      len = $urandom_range(8, 24);
    end else if (pick <= 7) begin
      k = $urandom_range(0, 4);
      t = err_types[k];
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, err_limits[k]));
      case ($urandom_range(0, 4))
        0: len = $urandom_range(8, 27);
        1: len = $urandom_range(28, 35);
        2: len = $urandom_range(36, 47);
        3: len = $urandom_range(48, 64);
        default: len = $urandom_range(65, 160);
      endcase
    end else if (pick == 8) begin
      t = 8'($urandom);
      c = 8'($urandom);
      len = $urandom_range(1, 40);
    end else begin
      t = 8'($urandom);
      c = 8'($urandom);
      len = $urandom_range(1, 7);
    end
    send_message(make_head(t, c, v, 4'($urandom), p), len);
  endtask

  initial begin
    rst = 1'b1;
    msg.valid = 1'b0;
    msg.byte_in = 8'd0;
    msg.last_byte = 1'b0;
    idle_on = 1'b1;
    bytes_sent = 0;
    msgs_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_message(make_head(TYPE_ECHO, 8'd0, IP_VERSION, 4'd5, PROTO_TCP), 1);
    send_message(make_head(TYPE_ECHO, 8'd0, IP_VERSION, 4'd5, PROTO_TCP), 7);
    foreach (query_types[i])
      send_message(make_head(query_types[i], 8'd0, IP_VERSION, 4'd5, PROTO_UDP), 8);
    send_message(make_head(TYPE_ECHO_REPLY, 8'hFF, IP_VERSION, 4'd5, PROTO_UDP), 8);
    send_message(make_head(8'hFF, 8'hFF, IP_VERSION, 4'd5, PROTO_TCP), 8);
    foreach (err_types[i]) begin
      send_message(make_head(err_types[i], err_limits[i], IP_VERSION, 4'd5, PROTO_TCP), 28);
      send_message(make_head(err_types[i], err_limits[i] + 8'd1, IP_VERSION, 4'd5, PROTO_TCP),
                   8);
    end
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, IP_VERSION, 4'd5, PROTO_UDP), 27);
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, IP_VERSION, 4'd5, PROTO_UDP), 28);
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, IP_VERSION, 4'd5, PROTO_UDP), 35);
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, IP_VERSION, 4'd5, PROTO_UDP), 36);
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, IP_VERSION, 4'd5, PROTO_TCP), 47);
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, IP_VERSION, 4'd5, PROTO_TCP), 48);
    send_message(make_head(TYPE_DEST_UNREACH, 8'd0, 4'd6, 4'd5, PROTO_TCP), 28);
    send_message(make_head(TYPE_REDIRECT, 8'd0, IP_VERSION, 4'hF, 8'hFF), 28);

    while (bytes_sent < RANDOM_BYTES || msgs_sent < RANDOM_MSGS) begin
      if (msgs_sent % 6 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random_message();
    end
    idle_on = 1'b0;
    repeat (2) send_random_message();
    msg.valid <= 1'b0;
    msg.last_byte <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/icmpv4_pkg.sv
sv/icmpv4_msg_if.sv
sv/icmpv4_res_if.sv
sv/icmpv4_decode.sv
sv/icmpv4_header_decoder.sv
tb/icmpv4_header_decoder_checker.sv
tb/icmpv4_header_decoder_test.sv
